/* sv/kf3_pkg.sv */
package kf3_pkg;

	localparam int N_ST          = 3;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IW        = 3;

	localparam logic [30:0] Q_RST = 31'd6554;
	localparam logic [30:0] R_RST = 31'd655;

	typedef enum logic [CFG_IW-1:0] {
		REG_Q0,
		REG_Q1,
		REG_Q2,
		REG_R0,
		REG_R1,
		REG_R2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} lane_req_t;

	typedef struct packed {
		logic done;
		logic clp;
	} lane_rsp_t;

	typedef struct packed {
		logic               clp;
		logic signed [31:0] v;
	} fx_t;

	// saturating a + b or a - b
	function automatic fx_t fx_addsub(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic sub);
		logic signed [32:0] s;
		fx_t r;
		s = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
		r.clp = 1'b0;
		r.v   = s[31:0];
		if (s > 33'sd2147483647) begin
			r.clp = 1'b1;
			r.v   = 32'sh7FFFFFFF;
		end else if (s < -33'sd2147483648) begin
			r.clp = 1'b1;
			r.v   = 32'sh80000000;
		end
		return r;
	endfunction

endpackage

/* sv/kf3_if.sv */
interface kf3_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [31:0] meas_0;
	logic signed [31:0] meas_1;
	logic signed [31:0] meas_2;
	modport source (output valid, func, meas_0, meas_1, meas_2, input ready);
	modport sink (input valid, func, meas_0, meas_1, meas_2, output ready);
endinterface

interface kf3_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] est_0;
	logic signed [31:0] est_1;
	logic signed [31:0] est_2;
	logic               singular;
	logic               saturated;
	modport source (output valid, est_0, est_1, est_2, singular, saturated, input ready);
	modport sink (input valid, est_0, est_1, est_2, singular, saturated, output ready);
endinterface

interface kf3_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/kalman_filter_3_state.sv */
// channel   dir   payload
// in_ch     in    func, meas_0..meas_2
// out_ch    out   est_0..est_2, singular, saturated
// cfg       in    index, data (q_noise_0..2, r_noise_0..2)
//
// Update time is set by the three bit-serial lane dividers (six division rounds) and
// the 3-deep multiply-accumulate sweeps. One item at a time; in_ch.ready is high only
// when idle. Reset: estimate zero, covariance identity, noise registers to defaults.
// A held output item stalls completion of the next item only at its final step.
module kalman_filter_3_state import kf3_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	kf3_in_if.sink    in_ch,
	kf3_out_if.source out_ch,
	kf3_cfg_if.sink   cfg
);

	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_PRED, S_INIT, S_PIV, S_DIVT, S_DIVI, S_ELT, S_ELI,
		S_GAIN, S_INNOV, S_EST, S_ESTM, S_IK, S_NEWP, S_COMMIT, S_FIN
	} state_t;

	state_t             st_q;
	logic               wait_q;
	logic [1:0]         ri_q, rj_q, rk_q;
	logic signed [31:0] p_q [N_ST][N_ST];
	logic signed [31:0] t_q [N_ST][N_ST];
	logic signed [31:0] inv_q [N_ST][N_ST];
	logic signed [31:0] g_q [N_ST][N_ST];
	logic signed [31:0] x_q [N_ST];
	logic signed [31:0] z_q [N_ST];
	logic signed [31:0] inn_q [N_ST];
	logic [30:0]        qn_q [N_ST];
	logic [30:0]        rn_q [N_ST];
	logic signed [31:0] d_q, f_q;
	logic               sat_q, sing_q, out_valid_q;

	lane_req_t          req [N_ST];
	lane_rsp_t          rsp [N_ST];
	logic signed [31:0] la [N_ST];
	logic signed [31:0] lb [N_ST];
	logic signed [31:0] lc [N_ST];
	logic signed [31:0] lres [N_ST];
	lane_rsp_t          mrsp;
	logic signed [31:0] mres;

	logic       issuing, go, lane_done, any_clp;
	op_t        lop;
	logic [2:0] first_j, next_j;

	assign in_ch.ready  = (st_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign out_ch.valid = out_valid_q;

	always_comb begin
		issuing = 1'b0;
		lop     = OP_ADD;
		case (st_q)
			S_PRED, S_INIT, S_GAIN, S_EST, S_NEWP: issuing = 1'b1;
			S_INNOV, S_ELT, S_ELI, S_IK: begin
				issuing = 1'b1;
				lop     = OP_SUB;
			end
			S_DIVT, S_DIVI: begin
				issuing = 1'b1;
				lop     = OP_DIV;
			end
			default: issuing = 1'b0;
		endcase
	end

	assign go        = (issuing || st_q == S_ESTM) && !wait_q;
	assign lane_done = rsp[0].done & rsp[1].done & rsp[2].done;
	assign any_clp   = rsp[0].clp | rsp[1].clp | rsp[2].clp;
	assign first_j   = (ri_q == 2'd0) ? 3'd1 : 3'd0;

	always_comb begin
		next_j = {1'b0, rj_q} + 3'd1;
		if (next_j == {1'b0, ri_q}) begin
			next_j = next_j + 3'd1;
		end
	end

	always_comb begin
		for (int l = 0; l < N_ST; l++) begin
			req[l].start = go && issuing;
			req[l].op    = lop;
			la[l] = 32'sd0;
			lb[l] = ONE;
			lc[l] = 32'sd0;
			case (st_q)
				S_PRED: begin
					lc[l] = p_q[l][l];
					la[l] = {1'b0, qn_q[l]};
				end
				S_INIT: begin
					lc[l] = p_q[l][l];
					la[l] = {1'b0, rn_q[l]};
				end
				S_DIVT: begin
					la[l] = t_q[ri_q][l];
					lb[l] = d_q;
				end
				S_DIVI: begin
					la[l] = inv_q[ri_q][l];
					lb[l] = d_q;
				end
				S_ELT: begin
					lc[l] = t_q[rj_q][l];
					la[l] = f_q;
					lb[l] = t_q[ri_q][l];
				end
				S_ELI: begin
					lc[l] = inv_q[rj_q][l];
					la[l] = f_q;
					lb[l] = inv_q[ri_q][l];
				end
				S_GAIN: begin
					lc[l] = (rk_q == 2'd0) ? 32'sd0 : lres[l];
					la[l] = p_q[ri_q][rk_q];
					lb[l] = inv_q[rk_q][l];
				end
				S_INNOV: begin
					lc[l] = z_q[l];
					la[l] = x_q[l];
				end
				S_EST: begin
					la[l] = g_q[ri_q][l];
					lb[l] = inn_q[l];
				end
				S_IK: begin
					lc[l] = (ri_q == 2'(l)) ? ONE : 32'sd0;
					la[l] = g_q[ri_q][l];
				end
				S_NEWP: begin
					lc[l] = (rk_q == 2'd0) ? 32'sd0 : lres[l];
					la[l] = g_q[ri_q][rk_q];
					lb[l] = p_q[rk_q][l];
				end
				default: lc[l] = 32'sd0;
			endcase
		end
	end

	for (genvar l = 0; l < N_ST; l++) begin : g_lane
		kf3_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.req    (req[l]),
			.a      (la[l]),
			.b      (lb[l]),
			.c      (lc[l]),
			.rsp    (rsp[l]),
			.res    (lres[l])
		);
	end

	kf3_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go && st_q == S_ESTM),
		.m      (lres),
		.base   (x_q[ri_q]),
		.rsp    (mrsp),
		.res    (mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			wait_q      <= 1'b0;
			ri_q        <= 2'd0;
			rj_q        <= 2'd0;
			rk_q        <= 2'd0;
			sat_q       <= 1'b0;
			sing_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < N_ST; r++) begin
				x_q[r]  <= 32'sd0;
				qn_q[r] <= Q_RST;
				rn_q[r] <= R_RST;
				for (int k = 0; k < N_ST; k++) begin
					p_q[r][k] <= (r == k) ? ONE : 32'sd0;
				end
			end
		end else begin
			if (cfg.valid) begin
				case (cfg_reg_t'(cfg.index))
					REG_Q0: qn_q[0] <= cfg.data[30:0];
					REG_Q1: qn_q[1] <= cfg.data[30:0];
					REG_Q2: qn_q[2] <= cfg.data[30:0];
					REG_R0: rn_q[0] <= cfg.data[30:0];
					REG_R1: rn_q[1] <= cfg.data[30:0];
					REG_R2: rn_q[2] <= cfg.data[30:0];
					default: ;
				endcase
			end

			if (go) begin
				wait_q <= 1'b1;
			end else if (lane_done || mrsp.done) begin
				wait_q <= 1'b0;
			end
			if (lane_done) begin
				sat_q <= sat_q | any_clp;
			end
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (st_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						z_q[0] <= in_ch.meas_0;
						z_q[1] <= in_ch.meas_1;
						z_q[2] <= in_ch.meas_2;
						sat_q  <= 1'b0;
						sing_q <= 1'b0;
						st_q   <= in_ch.func ? S_INIT : S_PRED;
					end
				end
				S_PRED: begin
					if (lane_done) begin
						for (int l = 0; l < N_ST; l++) p_q[l][l] <= lres[l];
						st_q <= S_FIN;
					end
				end
				S_INIT: begin
					if (lane_done) begin
						for (int r = 0; r < N_ST; r++) begin
							for (int k = 0; k < N_ST; k++) begin
								t_q[r][k]   <= (r == k) ? lres[k] : p_q[r][k];
								inv_q[r][k] <= (r == k) ? ONE : 32'sd0;
							end
						end
						ri_q <= 2'd0;
						st_q <= S_PIV;
					end
				end
				S_PIV: begin
					if (t_q[ri_q][ri_q] == 32'sd0) begin
						sing_q <= 1'b1;
						st_q   <= S_FIN;
					end else begin
						d_q  <= t_q[ri_q][ri_q];
						st_q <= S_DIVT;
					end
				end
				S_DIVT: begin
					if (lane_done) begin
						for (int l = 0; l < N_ST; l++) t_q[ri_q][l] <= lres[l];
						st_q <= S_DIVI;
					end
				end
				S_DIVI: begin
					if (lane_done) begin
						for (int l = 0; l < N_ST; l++) inv_q[ri_q][l] <= lres[l];
						rj_q <= first_j[1:0];
						f_q  <= t_q[first_j[1:0]][ri_q];
						st_q <= S_ELT;
					end
				end
				S_ELT: begin
					if (lane_done) begin
						for (int l = 0; l < N_ST; l++) t_q[rj_q][l] <= lres[l];
						st_q <= S_ELI;
					end
				end
				S_ELI: begin
					if (lane_done) begin
						for (int l = 0; l < N_ST; l++) inv_q[rj_q][l] <= lres[l];
						if (next_j < 3'd3) begin
							rj_q <= next_j[1:0];
							f_q  <= t_q[next_j[1:0]][ri_q];
							st_q <= S_ELT;
						end else if (ri_q == 2'd2) begin
							ri_q <= 2'd0;
							rk_q <= 2'd0;
							st_q <= S_GAIN;
						end else begin
							ri_q <= ri_q + 2'd1;
							st_q <= S_PIV;
						end
					end
				end
				S_GAIN: begin
					if (lane_done) begin
						if (rk_q == 2'd2) begin
							for (int l = 0; l < N_ST; l++) g_q[ri_q][l] <= lres[l];
							rk_q <= 2'd0;
							if (ri_q == 2'd2) begin
								ri_q <= 2'd0;
								st_q <= S_INNOV;
							end else begin
								ri_q <= ri_q + 2'd1;
							end
						end else begin
							rk_q <= rk_q + 2'd1;
						end
					end
				end
				S_INNOV: begin
					if (lane_done) begin
						for (int l = 0; l < N_ST; l++) inn_q[l] <= lres[l];
						ri_q <= 2'd0;
						st_q <= S_EST;
					end
				end
				S_EST: begin
					if (lane_done) st_q <= S_ESTM;
				end
				S_ESTM: begin
					if (mrsp.done) begin
						x_q[ri_q] <= mres;
						sat_q     <= sat_q | mrsp.clp;
						if (ri_q == 2'd2) begin
							ri_q <= 2'd0;
							st_q <= S_IK;
						end else begin
							ri_q <= ri_q + 2'd1;
							st_q <= S_EST;
						end
					end
				end
				S_IK: begin
					if (lane_done) begin
						for (int l = 0; l < N_ST; l++) g_q[ri_q][l] <= lres[l];
						if (ri_q == 2'd2) begin
							ri_q <= 2'd0;
							rk_q <= 2'd0;
							st_q <= S_NEWP;
						end else begin
							ri_q <= ri_q + 2'd1;
						end
					end
				end
				S_NEWP: begin
					if (lane_done) begin
						if (rk_q == 2'd2) begin
							for (int l = 0; l < N_ST; l++) t_q[ri_q][l] <= lres[l];
							rk_q <= 2'd0;
							if (ri_q == 2'd2) begin
								ri_q <= 2'd0;
								st_q <= S_COMMIT;
							end else begin
								ri_q <= ri_q + 2'd1;
							end
						end else begin
							rk_q <= rk_q + 2'd1;
						end
					end
				end
				S_COMMIT: begin
					p_q  <= t_q;
					st_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ch.ready) begin
						out_ch.est_0     <= x_q[0];
						out_ch.est_1     <= x_q[1];
						out_ch.est_2     <= x_q[2];
						out_ch.singular  <= sing_q;
						out_ch.saturated <= sat_q;
						out_valid_q      <= 1'b1;
						st_q             <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* sv/kf3_lane.sv */
module kf3_lane import kf3_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lane_req_t          req,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic signed [31:0] c,
	output lane_rsp_t          rsp,
	output logic signed [31:0] res
);

	localparam int NUMW = 32 + FRAC_BITS;
	localparam int CW   = $clog2(NUMW);
	localparam logic [NUMW-1:0] QMAXP = NUMW'(64'h7FFFFFFF);
	localparam logic [NUMW-1:0] QMAXN = NUMW'(64'h80000000);

	typedef enum logic [2:0] {L_IDLE, L_MUL, L_SHF, L_ADD, L_DIV, L_DFIN} lst_t;

	lst_t               st_q;
	op_t                op_q;
	logic signed [31:0] a_q, b_q, c_q;
	logic signed [63:0] prod_s1;
	logic signed [31:0] m_s2;
	logic               mclp_s2;
	logic [NUMW-1:0]    num_q;
	logic [31:0]        dv_q, rem_q;
	logic               neg_q;
	logic [CW-1:0]      cnt_q;

	logic signed [63:0] shf;
	logic [31:0]        a_abs, b_abs;
	logic [32:0]        remsh, diff;
	logic               ge;
	fx_t                sum;

	assign shf   = prod_s1 >>> FRAC_BITS;
	assign a_abs = a[31] ? (~a + 32'd1) : a;
	assign b_abs = b[31] ? (~b + 32'd1) : b;
	assign remsh = {rem_q, num_q[NUMW-1]};
	assign diff  = remsh - {1'b0, dv_q};
	assign ge    = remsh >= {1'b0, dv_q};
	assign sum   = fx_addsub(c_q, m_s2, op_q == OP_SUB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= L_IDLE;
			rsp.done <= 1'b0;
			rsp.clp  <= 1'b0;
		end else begin
			rsp.done <= 1'b0;
			case (st_q)
				L_IDLE: begin
					if (req.start) begin
						op_q <= req.op;
						a_q  <= a;
						b_q  <= b;
						c_q  <= c;
						if (req.op == OP_DIV) begin
							num_q <= {a_abs, FRAC_BITS'(0)};
							dv_q  <= b_abs;
							rem_q <= 32'd0;
							neg_q <= a[31] ^ b[31];
							cnt_q <= CW'(NUMW - 1);
							st_q  <= L_DIV;
						end else begin
							st_q <= L_MUL;
						end
					end
				end
				L_MUL: begin
					prod_s1 <= a_q * b_q;
					st_q    <= L_SHF;
				end
				L_SHF: begin
					mclp_s2 <= 1'b0;
					m_s2    <= shf[31:0];
					if (shf > 64'sh7FFFFFFF) begin
						mclp_s2 <= 1'b1;
						m_s2    <= 32'sh7FFFFFFF;
					end else if (shf < -64'sh80000000) begin
						mclp_s2 <= 1'b1;
						m_s2    <= 32'sh80000000;
					end
					st_q <= L_ADD;
				end
				L_ADD: begin
					res      <= sum.v;
					rsp.clp  <= sum.clp | mclp_s2;
					rsp.done <= 1'b1;
					st_q     <= L_IDLE;
				end
				L_DIV: begin
					rem_q <= ge ? diff[31:0] : remsh[31:0];
					num_q <= {num_q[NUMW-2:0], ge};
					if (cnt_q == '0) begin
						st_q <= L_DFIN;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				L_DFIN: begin
					rsp.done <= 1'b1;
					rsp.clp  <= 1'b0;
					if (neg_q) begin
						if (num_q > QMAXN) begin
							rsp.clp <= 1'b1;
							res     <= 32'sh80000000;
						end else begin
							res <= ~num_q[31:0] + 32'd1;
						end
					end else begin
						if (num_q > QMAXP) begin
							rsp.clp <= 1'b1;
							res     <= 32'sh7FFFFFFF;
						end else begin
							res <= num_q[31:0];
						end
					end
					st_q <= L_IDLE;
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

endmodule

/* sv/kf3_merge.sv */
module kf3_merge import kf3_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] m [N_ST],
	input  logic signed [31:0] base,
	output lane_rsp_t          rsp,
	output logic signed [31:0] res
);

	logic               v_s1;
	logic signed [31:0] s_s1, m2_s1, base_s1;
	logic               clp_s1;
	fx_t                s1, s2, s3;

	// left to right: ((m0 + m1) + m2), then base + that
	assign s1 = fx_addsub(m[0], m[1], 1'b0);
	assign s2 = fx_addsub(s_s1, m2_s1, 1'b0);
	assign s3 = fx_addsub(base_s1, s2.v, 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			rsp.done <= 1'b0;
			rsp.clp  <= 1'b0;
		end else begin
			v_s1     <= start;
			rsp.done <= v_s1;
			if (start) begin
				s_s1    <= s1.v;
				clp_s1  <= s1.clp;
				m2_s1   <= m[2];
				base_s1 <= base;
			end
			if (v_s1) begin
				res     <= s3.v;
				rsp.clp <= clp_s1 | s2.clp | s3.clp;
			end
		end
	end

endmodule

/* sv/kf3_check.sv */
module kf3_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] out_est_0,
	input logic               out_singular
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_est_0) && $stable(out_singular))
		else $error("output item changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without an item in flight");

endmodule

bind kalman_filter_3_state kf3_check u_kf3_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_est_0    (out_ch.est_0),
	.out_singular (out_ch.singular)
);
